>>> sv/llr_pkg.sv
package llr_pkg;

  // wheel speed ceiling
  localparam logic [7:0] SpeedCap = 8'd140;

  // mode codes
  localparam logic [2:0] ModeFollow = 3'd0;
  localparam logic [2:0] ModeSeekL  = 3'd1;
  localparam logic [2:0] ModeSeekR  = 3'd2;
  localparam logic [2:0] ModeAlign  = 3'd3;
  localparam logic [2:0] ModeStop   = 3'd4;

  // seek side codes
  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;

  // line event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvLost  = 2'd1;
  localparam logic [1:0] EvOther = 2'd2;
  localparam logic [1:0] EvNoEst = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CfgStaleLimit   = 3'd0;
  localparam logic [2:0] CfgMinConf      = 3'd1;
  localparam logic [2:0] CfgReacqNeeded  = 3'd2;
  localparam logic [2:0] CfgSeekSpeed    = 3'd3;
  localparam logic [2:0] CfgSeekSlow     = 3'd4;
  localparam logic [2:0] CfgHighYaw      = 3'd5;
  localparam logic [2:0] CfgAlignLimit   = 3'd6;
  localparam logic [2:0] CfgAlignTime    = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [1:0]         line_event;
    logic [31:0]        line_timestamp_ms;
    logic [15:0]        line_sequence;
    logic [7:0]         line_confidence;
    logic               predict_left;
    logic               follow_ok;
    logic signed [15:0] follow_forward;
    logic signed [15:0] follow_turn;
    logic signed [15:0] yaw_rate;
    logic               yaw_ok;
    logic               estop;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] wheel_l;
    logic [7:0] wheel_r;
    logic       request_valid;
    logic [2:0] mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] stale_limit_ms;
    logic [7:0]  min_confidence;
    logic [7:0]  reacquire_needed;
    logic [7:0]  seek_speed;
    logic [7:0]  seek_slow_speed;
    logic [14:0] high_yaw_rate;
    logic [7:0]  align_speed_limit;
    logic [15:0] align_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  seek_dir;
    logic [7:0]  reacq_cnt;
    logic [15:0] last_seq;
    logic        seq_seen;
    logic [31:0] mode_start_ms;
  } state_t;

  // clamp a signed wheel command into 0..lim
  function automatic logic [7:0] clamp_speed(logic signed [16:0] c, logic [7:0] lim);
    logic [7:0] r;
    if (c < 17'sd0) begin
      r = 8'd0;
    end else if (c > $signed({9'd0, lim})) begin
      r = lim;
    end else begin
      r = c[7:0];
    end
    return r;
  endfunction

endpackage

>>> sv/llr_in_if.sv
interface llr_in_if;
  import llr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> sv/llr_out_if.sv
interface llr_out_if;
  import llr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> sv/line_loss_recovery_fsm_unit.sv
// Line loss recovery controller: each input beat is one control tick and yields
// exactly one result beat carrying the clamped wheel speeds, a request flag and
// the mode after the tick. A new beat can be taken every clock cycle unless the
// result side stalls; a result beat is offered from the clock edge after its input
// beat is taken (input register, one pass of compare-and-select logic into the
// result register), later only while the result side stalls. Configuration writes
// take effect on the next tick and are meant to be issued while no tick is in flight.
module line_loss_recovery_fsm_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  llr_in_if.sink                          in_i,
  llr_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [llr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [llr_pkg::CfgDataW-1:0]    cfg_data_i
);
  import llr_pkg::*;

  cfg_t      cfg_q;
  state_t    state_q;
  state_t    state_d;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result_d;
  logic      advance;

  // handshake: the result register frees itself when taken
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit_ms    <= 16'd100;
      cfg_q.min_confidence    <= 8'd128;
      cfg_q.reacquire_needed  <= 8'd3;
      cfg_q.seek_speed        <= 8'd80;
      cfg_q.seek_slow_speed   <= 8'd50;
      cfg_q.high_yaw_rate     <= 15'd2400;
      cfg_q.align_speed_limit <= 8'd100;
      cfg_q.align_time_ms     <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStaleLimit:  cfg_q.stale_limit_ms    <= cfg_data_i;
        CfgMinConf:     cfg_q.min_confidence    <= cfg_data_i[7:0];
        CfgReacqNeeded: cfg_q.reacquire_needed  <= cfg_data_i[7:0];
        CfgSeekSpeed:   cfg_q.seek_speed        <= cfg_data_i[7:0];
        CfgSeekSlow:    cfg_q.seek_slow_speed   <= cfg_data_i[7:0];
        CfgHighYaw:     cfg_q.high_yaw_rate     <= cfg_data_i[14:0];
        CfgAlignLimit:  cfg_q.align_speed_limit <= cfg_data_i[7:0];
        CfgAlignTime:   cfg_q.align_time_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.item;
    end
  end

  // tick logic
  llr_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= ModeFollow;
      state_q.seek_dir      <= DirNone;
      state_q.reacq_cnt     <= 8'd0;
      state_q.last_seq      <= 16'd0;
      state_q.seq_seen      <= 1'b0;
      state_q.mode_start_ms <= 32'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  // checks
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.request_valid |->
      out_item_q.wheel_l == 8'd0 && out_item_q.wheel_r == 8'd0)
    else $error("speeds not zero without a request");

  a_speed_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_item_q.wheel_l <= SpeedCap && out_item_q.wheel_r <= SpeedCap)
    else $error("wheel speed above cap");

  a_seek_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.mode == ModeSeekL |-> out_item_q.wheel_l == 8'd0)
    else $error("left wheel driven during left seek");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled with room in the pipeline");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> state_q.mode == out_item_q.mode)
    else $error("reported mode differs from held mode");

endmodule

>>> sv/llr_step.sv
module llr_step (
  input  llr_pkg::cfg_t      cfg_i,
  input  llr_pkg::state_t    state_i,
  input  llr_pkg::in_item_t  item_i,
  output llr_pkg::state_t    state_o,
  output llr_pkg::out_item_t result_o
);
  import llr_pkg::*;

  logic [31:0]        age;
  logic [31:0]        mode_age;
  logic               go_stop;
  logic               seq_fresh;
  logic               trusty;
  logic               lost;
  logic [7:0]         cnt_inc;
  logic [7:0]         cnt_upd;
  logic               reacq_hit;
  logic               align_done;
  logic [15:0]        yaw_mag;
  logic [7:0]         seek_raw;
  logic [7:0]         seek_sp;
  logic [7:0]         align_lim;
  logic signed [16:0] sum_l;
  logic signed [16:0] sum_r;
  logic [1:0]         dir_lock;
  logic [1:0]         dir_keep;
  logic               do_seek;
  logic               do_follow;
  logic               use_alim;
  state_t             nxt;
  out_item_t          res;

  // freshness and stop condition
  assign age      = item_i.now_ms - item_i.line_timestamp_ms;
  assign mode_age = item_i.now_ms - state_i.mode_start_ms;
  assign go_stop  = item_i.estop || (item_i.line_event == EvNoEst) ||
                    (age > {16'd0, cfg_i.stale_limit_ms});

  // estimate classification
  assign seq_fresh = !(state_i.seq_seen && (item_i.line_sequence == state_i.last_seq));
  assign lost      = (item_i.line_event == EvLost);
  assign trusty    = (item_i.line_event == EvNone) &&
                     (item_i.line_confidence >= cfg_i.min_confidence);

  // saturating reacquire count
  assign cnt_inc   = (state_i.reacq_cnt == 8'hff) ? 8'hff : state_i.reacq_cnt + 8'd1;
  assign cnt_upd   = !trusty ? 8'd0 : (seq_fresh ? cnt_inc : state_i.reacq_cnt);
  assign reacq_hit = trusty && seq_fresh && (cnt_inc >= cfg_i.reacquire_needed);

  assign align_done = (mode_age >= {16'd0, cfg_i.align_time_ms});

  // pivot speed, slower at high yaw rate
  assign yaw_mag  = item_i.yaw_rate[15] ? (~item_i.yaw_rate + 16'd1) : item_i.yaw_rate;
  assign seek_raw = (item_i.yaw_ok && (yaw_mag >= {1'b0, cfg_i.high_yaw_rate})) ?
                    cfg_i.seek_slow_speed : cfg_i.seek_speed;
  assign seek_sp  = (seek_raw > SpeedCap) ? SpeedCap : seek_raw;

  assign align_lim = (cfg_i.align_speed_limit > SpeedCap) ? SpeedCap : cfg_i.align_speed_limit;

  // follow wheel sums
  assign sum_l = {item_i.follow_forward[15], item_i.follow_forward} -
                 {item_i.follow_turn[15], item_i.follow_turn};
  assign sum_r = {item_i.follow_forward[15], item_i.follow_forward} +
                 {item_i.follow_turn[15], item_i.follow_turn};

  // seek side when a seek starts
  assign dir_lock = item_i.predict_left ? DirLeft : DirRight;
  assign dir_keep = (state_i.seek_dir == DirNone) ? DirRight : state_i.seek_dir;

  // mode transitions
  always_comb begin
    nxt       = state_i;
    do_seek   = 1'b0;
    do_follow = 1'b0;
    use_alim  = 1'b0;
    if (go_stop) begin
      nxt.reacq_cnt     = 8'd0;
      nxt.mode          = ModeStop;
      nxt.mode_start_ms = item_i.now_ms;
    end else begin
      nxt.last_seq = item_i.line_sequence;
      nxt.seq_seen = 1'b1;
      unique case (state_i.mode)
        ModeFollow, ModeStop: begin
          if (lost) begin
            nxt.seek_dir      = dir_lock;
            nxt.reacq_cnt     = 8'd0;
            nxt.mode          = (dir_lock == DirLeft) ? ModeSeekL : ModeSeekR;
            nxt.mode_start_ms = item_i.now_ms;
            do_seek           = 1'b1;
          end else if (state_i.mode == ModeFollow) begin
            do_follow = 1'b1;
          end else begin
            nxt.reacq_cnt = cnt_upd;
            if (reacq_hit) begin
              nxt.mode          = ModeAlign;
              nxt.mode_start_ms = item_i.now_ms;
              do_follow         = 1'b1;
              use_alim          = 1'b1;
            end
          end
        end
        ModeSeekL, ModeSeekR: begin
          nxt.reacq_cnt = cnt_upd;
          if (reacq_hit) begin
            nxt.mode          = ModeAlign;
            nxt.mode_start_ms = item_i.now_ms;
            do_follow         = 1'b1;
            use_alim          = 1'b1;
          end else begin
            do_seek = 1'b1;
          end
        end
        ModeAlign: begin
          if (lost) begin
            nxt.seek_dir      = dir_keep;
            nxt.reacq_cnt     = 8'd0;
            nxt.mode          = (dir_keep == DirLeft) ? ModeSeekL : ModeSeekR;
            nxt.mode_start_ms = item_i.now_ms;
            do_seek           = 1'b1;
          end else if (align_done) begin
            nxt.reacq_cnt     = 8'd0;
            nxt.mode          = ModeFollow;
            nxt.mode_start_ms = item_i.now_ms;
            do_follow         = 1'b1;
          end else begin
            do_follow = 1'b1;
            use_alim  = 1'b1;
          end
        end
        default: begin
          // fault on an unknown mode code
          nxt.reacq_cnt     = 8'd0;
          nxt.mode          = ModeStop;
          nxt.mode_start_ms = item_i.now_ms;
        end
      endcase
    end
  end

  // wheel request
  always_comb begin
    res      = '0;
    res.mode = nxt.mode;
    if (do_seek) begin
      res.request_valid = 1'b1;
      if (nxt.seek_dir == DirLeft) begin
        res.wheel_r = seek_sp;
      end else begin
        res.wheel_l = seek_sp;
      end
    end else if (do_follow && item_i.follow_ok) begin
      res.request_valid = 1'b1;
      res.wheel_l       = clamp_speed(sum_l, use_alim ? align_lim : SpeedCap);
      res.wheel_r       = clamp_speed(sum_r, use_alim ? align_lim : SpeedCap);
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import llr_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  llr_in_if  tick_if ();
  llr_out_if req_if ();

  line_loss_recovery_fsm_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (req_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // controller copy: registers and recovery state
  cfg_t   ctl_cfg;
  state_t ctl_st;

  // wheel requests still owed by the block, oldest first
  out_item_t wheel_req_q[$];

  int unsigned err_cnt;
  int unsigned ticks_sent;
  int unsigned reqs_checked;
  int unsigned settings_cnt;
  int unsigned seek_seen;
  int unsigned align_seen;
  int unsigned stop_seen;
  bit          in_gap_off;
  bit          out_gap_off;
  logic [31:0] clock_ms;
  logic [15:0] seq_ctr;

  // ---------------------------------------------------------------------------
  // controller prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] clamp_wheel(int c, logic [7:0] lim);
    if (c < 0) return 8'd0;
    if (c > int'(lim)) return lim;
    return c[7:0];
  endfunction

  // follow command, clamped to lim
  function automatic out_item_t follow_cmd(in_item_t t, logic [7:0] lim);
    out_item_t r;
    int        fwd;
    int        turn;
    r    = '0;
    fwd  = int'($signed(t.follow_forward));
    turn = int'($signed(t.follow_turn));
    if (t.follow_ok) begin
      r.wheel_l       = clamp_wheel(fwd - turn, lim);
      r.wheel_r       = clamp_wheel(fwd + turn, lim);
      r.request_valid = 1'b1;
    end
    return r;
  endfunction

  // pivot toward the seek side, slow when the yaw rate is high and trusted
  function automatic out_item_t seek_cmd(in_item_t t, logic [1:0] dir);
    out_item_t  r;
    int         yaw_mag;
    logic [7:0] sp;
    r       = '0;
    yaw_mag = int'($signed(t.yaw_rate));
    if (yaw_mag < 0) yaw_mag = -yaw_mag;
    if (t.yaw_ok && yaw_mag >= int'(ctl_cfg.high_yaw_rate)) begin
      sp = ctl_cfg.seek_slow_speed;
    end else begin
      sp = ctl_cfg.seek_speed;
    end
    if (sp > SpeedCap) sp = SpeedCap;
    if (dir == DirLeft) begin
      r.wheel_r = sp;
    end else begin
      r.wheel_l = sp;
    end
    r.request_valid = 1'b1;
    return r;
  endfunction

  task automatic set_mode(input logic [2:0] m, input logic [31:0] now);
    ctl_st.mode          = m;
    ctl_st.mode_start_ms = now;
  endtask

  task automatic start_seek(input in_item_t t, input bit lock);
    if (lock) begin
      ctl_st.seek_dir = t.predict_left ? DirLeft : DirRight;
    end else if (ctl_st.seek_dir == DirNone) begin
      ctl_st.seek_dir = DirRight;
    end
    ctl_st.reacq_cnt = 8'd0;
    set_mode(ctl_st.seek_dir == DirLeft ? ModeSeekL : ModeSeekR, t.now_ms);
  endtask

  // one control tick: update the state copy and work out the wheel request
  task automatic recovery_step(input in_item_t t, output out_item_t r);
    logic [7:0]  alim;
    logic [31:0] age;
    logic [31:0] in_mode_ms;
    bit          lost;
    bit          trusty;
    bit          new_est;
    bit          reacq;
    alim = (ctl_cfg.align_speed_limit > SpeedCap) ? SpeedCap : ctl_cfg.align_speed_limit;
    age  = t.now_ms - t.line_timestamp_ms;
    r    = '0;
    if (t.estop || t.line_event == EvNoEst ||
        age > {16'd0, ctl_cfg.stale_limit_ms}) begin
      ctl_st.reacq_cnt = 8'd0;
      set_mode(ModeStop, t.now_ms);
    end else begin
      new_est         = !(ctl_st.seq_seen && t.line_sequence == ctl_st.last_seq);
      ctl_st.last_seq = t.line_sequence;
      ctl_st.seq_seen = 1'b1;
      lost            = (t.line_event == EvLost);
      trusty          = (t.line_event == EvNone) &&
                        (t.line_confidence >= ctl_cfg.min_confidence);
      // reacquire counting happens while seeking, and while stopped unless lost
      reacq = 1'b0;
      if (ctl_st.mode == ModeSeekL || ctl_st.mode == ModeSeekR ||
          (ctl_st.mode == ModeStop && !lost)) begin
        if (!trusty) begin
          ctl_st.reacq_cnt = 8'd0;
        end else if (new_est) begin
          if (ctl_st.reacq_cnt != 8'd255) ctl_st.reacq_cnt++;
          reacq = (ctl_st.reacq_cnt >= ctl_cfg.reacquire_needed);
        end
      end
      case (ctl_st.mode)
        ModeFollow: begin
          if (lost) begin
            start_seek(t, 1'b1);
            r = seek_cmd(t, ctl_st.seek_dir);
          end else begin
            r = follow_cmd(t, SpeedCap);
          end
        end
        ModeSeekL, ModeSeekR: begin
          if (reacq) begin
            set_mode(ModeAlign, t.now_ms);
            r = follow_cmd(t, alim);
          end else begin
            r = seek_cmd(t, ctl_st.seek_dir);
          end
        end
        ModeAlign: begin
          in_mode_ms = t.now_ms - ctl_st.mode_start_ms;
          if (lost) begin
            start_seek(t, 1'b0);
            r = seek_cmd(t, ctl_st.seek_dir);
          end else if (in_mode_ms >= {16'd0, ctl_cfg.align_time_ms}) begin
            ctl_st.reacq_cnt = 8'd0;
            set_mode(ModeFollow, t.now_ms);
            r = follow_cmd(t, SpeedCap);
          end else begin
            r = follow_cmd(t, alim);
          end
        end
        ModeStop: begin
          if (lost) begin
            start_seek(t, 1'b1);
            r = seek_cmd(t, ctl_st.seek_dir);
          end else if (reacq) begin
            set_mode(ModeAlign, t.now_ms);
            r = follow_cmd(t, alim);
          end
        end
        default: begin
          ctl_st.reacq_cnt = 8'd0;
          set_mode(ModeStop, t.now_ms);
        end
      endcase
    end
    r.mode = ctl_st.mode;
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // send one tick beat after a random gap, predict it once taken
  task automatic send_tick(input in_item_t t);
    int        gap;
    out_item_t want;
    gap = in_gap_off ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.item  <= t;
    do @(posedge clk_i); while (!tick_if.ready);
    recovery_step(t, want);
    wheel_req_q.push_back(want);
    ticks_sent++;
  endtask

  // hold off until every owed request has come back
  task automatic drain_ticks();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (wheel_req_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgStaleLimit:  ctl_cfg.stale_limit_ms    = data;
      CfgMinConf:     ctl_cfg.min_confidence    = data[7:0];
      CfgReacqNeeded: ctl_cfg.reacquire_needed  = data[7:0];
      CfgSeekSpeed:   ctl_cfg.seek_speed        = data[7:0];
      CfgSeekSlow:    ctl_cfg.seek_slow_speed   = data[7:0];
      CfgHighYaw:     ctl_cfg.high_yaw_rate     = data[14:0];
      CfgAlignLimit:  ctl_cfg.align_speed_limit = data[7:0];
      CfgAlignTime:   ctl_cfg.align_time_ms     = data;
      default: ;
    endcase
  endtask

  // reprogram every register once the block has gone quiet
  task automatic program_regs(input logic [15:0] stale, input logic [15:0] conf,
                              input logic [15:0] reacq, input logic [15:0] seek,
                              input logic [15:0] slow, input logic [15:0] yaw,
                              input logic [15:0] alim, input logic [15:0] atime);
    drain_ticks();
    write_reg(CfgStaleLimit, stale);
    write_reg(CfgMinConf, conf);
    write_reg(CfgReacqNeeded, reacq);
    write_reg(CfgSeekSpeed, seek);
    write_reg(CfgSeekSlow, slow);
    write_reg(CfgHighYaw, yaw);
    write_reg(CfgAlignLimit, alim);
    write_reg(CfgAlignTime, atime);
    settings_cnt++;
  endtask

  // fresh tick with a gentle follow command; advances the clock
  function automatic in_item_t nominal_tick(logic [1:0] ev, logic [15:0] seq,
                                            logic [7:0] conf);
    in_item_t t;
    clock_ms            = clock_ms + 32'd10;
    t                   = '0;
    t.line_event        = ev;
    t.line_timestamp_ms = clock_ms;
    t.line_sequence     = seq;
    t.line_confidence   = conf;
    t.follow_ok         = 1'b1;
    t.follow_forward    = 16'sd60;
    t.follow_turn       = 16'sd10;
    t.yaw_ok            = 1'b1;
    t.now_ms            = clock_ms;
    return t;
  endfunction

  // mostly plausible ticks with random content, some pure noise
  task automatic draw_tick(output in_item_t t);
    int unsigned roll;
    int unsigned age;
    t = '0;
    if ($urandom_range(0, 99) < 12) begin
      t.line_event        = 2'($urandom);
      t.line_timestamp_ms = $urandom;
      t.line_sequence     = 16'($urandom);
      t.line_confidence   = 8'($urandom);
      t.predict_left      = 1'($urandom);
      t.follow_ok         = 1'($urandom);
      t.follow_forward    = 16'($urandom);
      t.follow_turn       = 16'($urandom);
      t.yaw_rate          = 16'($urandom);
      t.yaw_ok            = 1'($urandom);
      t.estop             = 1'($urandom);
      t.now_ms            = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0) begin
        age = int'(ctl_cfg.stale_limit_ms) + $urandom_range(1, 500);
      end else begin
        age = $urandom_range(0, int'(ctl_cfg.stale_limit_ms));
      end
      if ($urandom_range(0, 99) < 85) seq_ctr = seq_ctr + 16'd1;
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        t.line_event = EvNone;
      end else if (roll < 86) begin
        t.line_event = EvLost;
      end else if (roll < 95) begin
        t.line_event = EvOther;
      end else begin
        t.line_event = EvNoEst;
      end
      t.now_ms            = clock_ms;
      t.line_timestamp_ms = clock_ms - age;
      t.line_sequence     = seq_ctr;
      if ($urandom_range(0, 99) < 80) begin
        t.line_confidence = 8'($urandom_range(int'(ctl_cfg.min_confidence), 255));
      end else begin
        t.line_confidence = 8'($urandom);
      end
      t.predict_left   = 1'($urandom);
      t.follow_ok      = ($urandom_range(0, 9) != 0);
      t.follow_forward = 16'(int'($urandom_range(0, 300)) - 80);
      t.follow_turn    = 16'(int'($urandom_range(0, 300)) - 150);
      if ($urandom_range(0, 9) < 7) begin
        t.yaw_rate = 16'(int'($urandom_range(0, 8000)) - 4000);
      end else begin
        t.yaw_rate = 16'($urandom);
      end
      t.yaw_ok = ($urandom_range(0, 99) < 85);
      t.estop  = ($urandom_range(0, 99) < 3);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare against the oldest owed request
  // ---------------------------------------------------------------------------

  initial begin : drive_req_ready
    int stall;
    req_if.ready <= 1'b0;
    forever begin
      stall = out_gap_off ? 0 : $urandom_range(0, 18);
      repeat (stall) begin
        req_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      req_if.ready <= 1'b1;
      do @(posedge clk_i); while (req_if.valid !== 1'b1);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                reqs_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_wheel_req
    out_item_t want;
    out_item_t got;
    if (rst_ni && req_if.valid && req_if.ready) begin
      got = req_if.item;
      if (wheel_req_q.size() == 0) begin
        report_mismatch("result beat with no request owed");
      end else begin
        want = wheel_req_q.pop_front();
        check_field("wheel_l", got.wheel_l, want.wheel_l);
        check_field("wheel_r", got.wheel_r, want.wheel_r);
        check_field("request_valid", {7'd0, got.request_valid}, {7'd0, want.request_valid});
        check_field("mode", {5'd0, got.mode}, {5'd0, want.mode});
        if (want.mode == ModeSeekL || want.mode == ModeSeekR) seek_seen++;
        if (want.mode == ModeAlign) align_seen++;
        if (want.mode == ModeStop) stop_seen++;
        reqs_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // from reset no seek side is locked: reacquire out of stop, then lose the
  // line during align, which must seek right
  task automatic test_align_without_side();
    in_item_t t;
    clock_ms = 32'd1000;
    t = nominal_tick(EvNone, 16'd0, 8'd200);
    t.estop = 1'b1;
    send_tick(t);
    send_tick(nominal_tick(EvNone, 16'd1, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd2, 8'd128));
    send_tick(nominal_tick(EvNone, 16'd3, 8'd255));
    t = nominal_tick(EvLost, 16'd4, 8'd0);
    t.predict_left = 1'b1;
    send_tick(t);
  endtask

  // align clamp, align timeout, then follow with extreme commands
  task automatic test_follow_clamp();
    in_item_t t;
    send_tick(nominal_tick(EvNone, 16'd10, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd11, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd12, 8'd200));
    t = nominal_tick(EvNone, 16'd13, 8'd200);
    t.follow_forward = 16'sd200;
    t.follow_turn    = -16'sd5;
    send_tick(t);
    clock_ms = clock_ms + 32'd300;
    send_tick(nominal_tick(EvOther, 16'd14, 8'd0));
    t = nominal_tick(EvNone, 16'hFFFF, 8'd255);
    t.follow_forward = 16'sh7FFF;
    t.follow_turn    = 16'sh8000;
    send_tick(t);
    t = nominal_tick(EvNone, 16'd15, 8'd255);
    t.follow_forward = 16'sh8000;
    t.follow_turn    = 16'sh7FFF;
    send_tick(t);
    t = nominal_tick(EvNone, 16'd16, 8'd255);
    t.follow_ok = 1'b0;
    send_tick(t);
  endtask

  // age at the limit, just past it, no estimate, and a wrapping clock
  task automatic test_freshness();
    in_item_t t;
    t = nominal_tick(EvNone, 16'd20, 8'd200);
    t.line_timestamp_ms = t.now_ms - 32'd100;
    send_tick(t);
    t = nominal_tick(EvNone, 16'd21, 8'd200);
    t.line_timestamp_ms = t.now_ms - 32'd101;
    send_tick(t);
    send_tick(nominal_tick(EvNoEst, 16'd22, 8'd200));
    t = nominal_tick(EvNone, 16'd23, 8'd200);
    t.now_ms            = 32'd5;
    t.line_timestamp_ms = 32'hFFFF_FFF0;
    send_tick(t);
  endtask

  // seek left at slow and full speed, repeated and untrusted estimates,
  // reacquire, then lose the line during align keeping the left side
  task automatic test_seek_paths();
    in_item_t t;
    t = nominal_tick(EvLost, 16'd30, 8'd0);
    t.predict_left = 1'b1;
    t.yaw_rate     = 16'sh8000;
    send_tick(t);
    t = nominal_tick(EvOther, 16'd31, 8'd255);
    t.yaw_rate = 16'sh8000;
    t.yaw_ok   = 1'b0;
    send_tick(t);
    send_tick(nominal_tick(EvNone, 16'd32, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd32, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd33, 8'd10));
    send_tick(nominal_tick(EvNone, 16'd34, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd35, 8'd200));
    send_tick(nominal_tick(EvNone, 16'd36, 8'd200));
    send_tick(nominal_tick(EvLost, 16'd37, 8'd0));
  endtask

  // zero reacquire target and speed settings above the cap
  task automatic test_zero_target();
    in_item_t t;
    program_regs(16'd100, 16'd128, 16'd0, 16'd255, 16'd200, 16'd0, 16'd255, 16'd300);
    send_tick(nominal_tick(EvOther, 16'd40, 8'd0));
    t = nominal_tick(EvNone, 16'd41, 8'd200);
    t.follow_forward = 16'sd300;
    send_tick(t);
    t = nominal_tick(EvNone, 16'd42, 8'd200);
    t.estop = 1'b1;
    send_tick(t);
    send_tick(nominal_tick(EvNone, 16'd43, 8'd200));
  endtask

  // random ticks under a run of register settings, extremes included
  task automatic test_random_settings();
    in_item_t t;
    for (int p = 0; p < 10; p++) begin
      in_gap_off  = (p == 3) || (p == 6);
      out_gap_off = (p == 3) || (p == 5);
      case (p)
        0: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_regs(16'd100, 16'd128, 16'd3, 16'd80, 16'd50, 16'd2400, 16'd100, 16'd300);
        default: program_regs(16'($urandom_range(0, 300)), 16'($urandom),
                              16'($urandom_range(0, 6)),
                              16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                              16'($urandom_range(0, 5000)), 16'($urandom_range(0, 255)),
                              16'($urandom_range(0, 400)));
      endcase
      clock_ms = (p == 7) ? 32'hFFFF_FE00 : $urandom;
      seq_ctr  = 16'($urandom);
      for (int n = 0; n < 95; n++) begin
        // one mid-phase pause until the block has answered everything
        if (p == 4 && n == 47) drain_ticks();
        draw_tick(t);
        send_tick(t);
      end
    end
    in_gap_off  = 1'b0;
    out_gap_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    tick_if.valid <= 1'b0;
    tick_if.item  <= '0;
    ctl_st        = '0;
    ctl_cfg.stale_limit_ms    = 16'd100;
    ctl_cfg.min_confidence    = 8'd128;
    ctl_cfg.reacquire_needed  = 8'd3;
    ctl_cfg.seek_speed        = 8'd80;
    ctl_cfg.seek_slow_speed   = 8'd50;
    ctl_cfg.high_yaw_rate     = 15'd2400;
    ctl_cfg.align_speed_limit = 8'd100;
    ctl_cfg.align_time_ms     = 16'd300;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_align_without_side();
    test_follow_clamp();
    test_freshness();
    test_seek_paths();
    test_zero_target();
    test_random_settings();

    drain_ticks();
    repeat (6) @(posedge clk_i);
    $display("covered %0d ticks over %0d register settings, %0d results compared",
             ticks_sent, settings_cnt + 1, reqs_checked);
    $display("results by mode: %0d seeking, %0d aligning, %0d stopped, %0d mismatches",
             seek_seen, align_seen, stop_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("line_loss_recovery_fsm_unit regression: pass");
    end else begin
      $display("line_loss_recovery_fsm_unit regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout waiting for the block");
    $display("line_loss_recovery_fsm_unit regression: fail");
    $finish;
  end

endmodule
